### sv/pearson_correlation_engine_defines.svh
// Assertion macros used by the correlation engine back end (pce_back).
`ifndef PEARSON_CORRELATION_ENGINE_DEFINES_SVH
`define PEARSON_CORRELATION_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define PCE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PCE_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PCE_ASSERT(lbl, clk, rstn, prop, msg)
`define PCE_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

### sv/pce_pkg.sv
`default_nettype none
package pce_pkg;
    localparam int DEF_MAX_SAMPLES   = 4096;
    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_OUT_FRAC_BITS = 15;
    localparam int PORT_SAMPLE_W     = 16;
    localparam int RESULT_W          = 16;
    localparam int STATUS_W          = 2;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_VAR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
endpackage
`default_nettype wire

### sv/pce_front.sv
`default_nettype none
module pce_front #(
    parameter int MAX_SAMPLES = pce_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = pce_pkg::DEF_SAMPLE_BITS,
    parameter int CW          = 13,
    parameter int SUMW        = 28,
    parameter int PW          = 44
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    accept,
    input  wire logic signed [pce_pkg::PORT_SAMPLE_W-1:0] x_sample,
    input  wire logic signed [pce_pkg::PORT_SAMPLE_W-1:0] y_sample,
    input  wire logic                                    last_pair,
    output logic                                         push,
    output logic [CW+2*SUMW+3*PW-1:0]                    push_data
);
    logic signed [SAMPLE_BITS-1:0]   xs, ys;
    logic signed [2*SAMPLE_BITS-1:0] xy, xx, yy;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic signed [SUMW-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic signed [PW-1:0]   sxy_reg, sxx_reg, syy_reg, sxy_next, sxx_next, syy_next;

    // Samples wider than the port are taken as plain positive values.
    generate
        if (SAMPLE_BITS <= pce_pkg::PORT_SAMPLE_W) begin : g_narrow
            assign xs = x_sample[SAMPLE_BITS-1:0];
            assign ys = y_sample[SAMPLE_BITS-1:0];
        end else begin : g_wide
            assign xs = {{(SAMPLE_BITS-pce_pkg::PORT_SAMPLE_W){1'b0}}, x_sample};
            assign ys = {{(SAMPLE_BITS-pce_pkg::PORT_SAMPLE_W){1'b0}}, y_sample};
        end
    endgenerate

    assign xy = xs * ys;
    assign xx = xs * xs;
    assign yy = ys * ys;

    always_comb
    begin
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sxy_next = sxy_reg;
        sxx_next = sxx_reg;
        syy_next = syy_reg;
        if (cnt_reg < CW'(MAX_SAMPLES))
        begin
            cnt_next = cnt_reg + 1'b1;
            sx_next  = sx_reg + SUMW'(xs);
            sy_next  = sy_reg + SUMW'(ys);
            sxy_next = sxy_reg + PW'(xy);
            sxx_next = sxx_reg + PW'(xx);
            syy_next = syy_reg + PW'(yy);
        end
        else
        begin
            cnt_next = CW'(MAX_SAMPLES + 1);
        end
    end

    assign push      = accept && last_pair;
    assign push_data = {cnt_next, sx_next, sy_next, sxy_next, sxx_next, syy_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
        end
        else if (accept)
        begin
            if (last_pair)
            begin
                cnt_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxy_reg <= '0;
                sxx_reg <= '0;
                syy_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sx_reg  <= sx_next;
                sy_reg  <= sy_next;
                sxy_reg <= sxy_next;
                sxx_reg <= sxx_next;
                syy_reg <= syy_next;
            end
        end
    end
endmodule
`default_nettype wire

### sv/pce_queue.sv
`default_nettype none
module pce_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic [W-1:0]      head,
    output logic              empty,
    output logic              full
);
    localparam int DEPTH = pce_pkg::QUEUE_DEPTH;
    localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [W-1:0]    mem_reg [DEPTH];
    logic [PTRW-1:0] wr_reg, rd_reg;
    logic [CNTW-1:0] cnt_reg;

    assign head  = mem_reg[rd_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNTW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTRW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

### sv/pce_mul.sv
`default_nettype none
module pce_mul #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              done,
    output logic [2*W-1:0]    p
);
    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg, a_reg;
    logic [W-1:0]   b_reg;
    logic [CW-1:0]  cnt_reg;
    logic           run_reg, done_reg;

    // Shift-and-add, one multiplier bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                acc_reg <= '0;
                a_reg   <= (2*W)'(a);
                b_reg   <= b;
            end
            else if (run_reg)
            begin
                if (b_reg[0])
                    acc_reg <= acc_reg + a_reg;
                a_reg   <= a_reg << 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule
`default_nettype wire

### sv/pce_back.sv
`default_nettype none
`include "pearson_correlation_engine_defines.svh"
module pce_back #(
    parameter int MAX_SAMPLES   = pce_pkg::DEF_MAX_SAMPLES,
    parameter int OUT_FRAC_BITS = pce_pkg::DEF_OUT_FRAC_BITS,
    parameter int CW            = 13,
    parameter int SUMW          = 28,
    parameter int PW            = 44
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [CW+2*SUMW+3*PW-1:0]     head,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               done,
    output logic signed [pce_pkg::RESULT_W-1:0] correlation,
    output logic [pce_pkg::STATUS_W-1:0]        status
);
    localparam int F     = OUT_FRAC_BITS;
    localparam int VW    = (CW + PW > 2 * SUMW) ? CW + PW : 2 * SUMW;
    localparam int MW    = VW + 1;
    localparam int RW    = 2 * MW + 2 * F;
    localparam int DQW   = 2 * F + 1;
    localparam int QW    = F + 1;
    localparam int DBW   = $clog2(DQW);
    localparam int SBW   = $clog2(QW);
    localparam int RES_W = (F + 2 > pce_pkg::RESULT_W) ? F + 2 : pce_pkg::RESULT_W;

    typedef enum logic [2:0] {S_IDLE, S_MUL_GO, S_MUL_WAIT, S_DIV, S_SQRT} state_t;
    typedef enum logic [2:0] {
        OP_NXX, OP_XX, OP_NYY, OP_YY, OP_NXY, OP_XY, OP_VV, OP_NUM
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    logic [CW-1:0]          n_reg;
    logic signed [SUMW-1:0] sx_reg, sy_reg;
    logic signed [PW-1:0]   sxy_reg, sxx_reg, syy_reg;
    logic [VW-1:0]          tmp_reg, vx_reg, vy_reg;
    logic [MW-1:0]          num_reg;
    logic                   neg_reg;
    logic [2*VW-1:0]        vv_reg;
    logic [RW-1:0]          rem_reg, dsh_reg;
    logic [DQW-1:0]         dq_reg;
    logic [QW-1:0]          q_reg;
    logic [DBW-1:0]         dbit_reg;
    logic [SBW-1:0]         sbit_reg;
    logic                   done_reg;
    logic signed [pce_pkg::RESULT_W-1:0] corr_reg;
    logic [pce_pkg::STATUS_W-1:0]        status_reg;

    logic [CW-1:0]          h_n;
    logic signed [SUMW-1:0] h_sx, h_sy;
    logic signed [PW-1:0]   h_sxy, h_sxx, h_syy;
    logic [SUMW-1:0]        ax, ay;
    logic [PW-1:0]          axy;
    logic [MW-1:0]          op_a, op_b;
    logic                   mul_start, mul_done;
    logic [2*MW-1:0]        mul_p;
    logic [VW-1:0]          p_v, var_v;
    logic [VW-1:0]          b_v;
    logic                   sa, sb;
    logic [QW-1:0]          cand, q_fin;
    logic [2*QW-1:0]        cand_sq;
    logic signed [RES_W-1:0] res_val;

    assign {h_n, h_sx, h_sy, h_sxy, h_sxx, h_syy} = head;

    assign ax  = sx_reg[SUMW-1] ? SUMW'(-sx_reg) : SUMW'(sx_reg);
    assign ay  = sy_reg[SUMW-1] ? SUMW'(-sy_reg) : SUMW'(sy_reg);
    assign axy = sxy_reg[PW-1] ? PW'(-sxy_reg) : PW'(sxy_reg);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (op_reg)
            OP_NXX: begin op_a = MW'(n_reg);   op_b = MW'($unsigned(sxx_reg)); end
            OP_XX:  begin op_a = MW'(ax);      op_b = MW'(ax);                 end
            OP_NYY: begin op_a = MW'(n_reg);   op_b = MW'($unsigned(syy_reg)); end
            OP_YY:  begin op_a = MW'(ay);      op_b = MW'(ay);                 end
            OP_NXY: begin op_a = MW'(n_reg);   op_b = MW'(axy);                end
            OP_XY:  begin op_a = MW'(ax);      op_b = MW'(ay);                 end
            OP_VV:  begin op_a = MW'(vx_reg);  op_b = MW'(vy_reg);             end
            OP_NUM: begin op_a = num_reg;      op_b = num_reg;                 end
            default: begin op_a = '0;          op_b = '0;                      end
        endcase
    end

    assign mul_start = (state_reg == S_MUL_GO);

    pce_mul #(.W(MW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Variance is n*sum_sq - sum^2, clamped at zero.
    assign p_v   = mul_p[VW-1:0];
    assign var_v = (tmp_reg > p_v) ? tmp_reg - p_v : '0;
    assign b_v   = p_v;
    assign sa    = sxy_reg[PW-1];
    assign sb    = !(sx_reg[SUMW-1] != sy_reg[SUMW-1]);

    assign cand    = q_reg | (QW'(1) << sbit_reg);
    assign cand_sq = cand * cand;
    assign q_fin   = ((2*QW)'(dq_reg) >= cand_sq) ? cand : q_reg;

    always_comb
    begin
        if (neg_reg)
            res_val = -RES_W'($signed({1'b0, q_fin}));
        else if (q_fin > QW'((1 << F) - 1))
            res_val = RES_W'((1 << F) - 1);
        else
            res_val = RES_W'($signed({1'b0, q_fin}));
    end

    assign pop = (state_reg == S_IDLE) && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_NXX;
            done_reg   <= 1'b0;
            corr_reg   <= '0;
            status_reg <= pce_pkg::STATUS_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        n_reg   <= h_n;
                        sx_reg  <= h_sx;
                        sy_reg  <= h_sy;
                        sxy_reg <= h_sxy;
                        sxx_reg <= h_sxx;
                        syy_reg <= h_syy;
                        op_reg  <= OP_NXX;
                        if (h_n > CW'(MAX_SAMPLES))
                        begin
                            done_reg   <= 1'b1;
                            corr_reg   <= '0;
                            status_reg <= pce_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            state_reg <= S_MUL_GO;
                        end
                    end
                end
                S_MUL_GO:
                begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_MUL_GO;
                        unique case (op_reg)
                            OP_NXX:
                            begin
                                tmp_reg <= p_v;
                                op_reg  <= OP_XX;
                            end
                            OP_XX:
                            begin
                                vx_reg <= var_v;
                                op_reg <= OP_NYY;
                            end
                            OP_NYY:
                            begin
                                tmp_reg <= p_v;
                                op_reg  <= OP_YY;
                            end
                            OP_YY:
                            begin
                                vy_reg <= var_v;
                                op_reg <= OP_NXY;
                                if (vx_reg == '0 || var_v == '0)
                                begin
                                    state_reg  <= S_IDLE;
                                    done_reg   <= 1'b1;
                                    corr_reg   <= '0;
                                    status_reg <= pce_pkg::STATUS_ZERO_VAR;
                                end
                            end
                            OP_NXY:
                            begin
                                tmp_reg <= p_v;
                                op_reg  <= OP_XY;
                            end
                            OP_XY:
                            begin
                                op_reg <= OP_VV;
                                if (sa == sb)
                                begin
                                    num_reg <= MW'(tmp_reg) + MW'(b_v);
                                    neg_reg <= sa;
                                end
                                else if (tmp_reg >= b_v)
                                begin
                                    num_reg <= MW'(tmp_reg - b_v);
                                    neg_reg <= sa;
                                end
                                else
                                begin
                                    num_reg <= MW'(b_v - tmp_reg);
                                    neg_reg <= sb;
                                end
                            end
                            OP_VV:
                            begin
                                vv_reg <= mul_p[2*VW-1:0];
                                op_reg <= OP_NUM;
                            end
                            OP_NUM:
                            begin
                                rem_reg   <= {mul_p, {(2*F){1'b0}}};
                                dsh_reg   <= {(2*MW-2*VW)'(0), vv_reg, {(2*F){1'b0}}};
                                dq_reg    <= '0;
                                dbit_reg  <= DBW'(2 * F);
                                state_reg <= S_DIV;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    // Restoring division: one quotient bit per cycle.
                    if (rem_reg >= dsh_reg)
                    begin
                        rem_reg          <= rem_reg - dsh_reg;
                        dq_reg[dbit_reg] <= 1'b1;
                    end
                    dsh_reg <= dsh_reg >> 1;
                    if (dbit_reg == '0)
                    begin
                        q_reg     <= '0;
                        sbit_reg  <= SBW'(F);
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        dbit_reg <= dbit_reg - 1'b1;
                    end
                end
                S_SQRT:
                begin
                    q_reg <= q_fin;
                    if (sbit_reg == '0)
                    begin
                        state_reg  <= S_IDLE;
                        done_reg   <= 1'b1;
                        corr_reg   <= res_val[pce_pkg::RESULT_W-1:0];
                        status_reg <= pce_pkg::STATUS_OK;
                    end
                    else
                    begin
                        sbit_reg <= sbit_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign correlation = corr_reg;
    assign status      = status_reg;

    `PCE_ASSERT(a_done_one_beat, clk, rst_n, done_reg |=> !done_reg, "result strobe held")
    `PCE_NEVER(a_pop_empty, clk, rst_n, pop && empty, "pop from empty queue")
    `PCE_NEVER(a_status_code, clk, rst_n, done_reg && status_reg != pce_pkg::STATUS_OK && status_reg != pce_pkg::STATUS_ZERO_VAR && status_reg != pce_pkg::STATUS_OVERFLOW, "bad status")
    `PCE_NEVER(a_err_nonzero, clk, rst_n, done_reg && status_reg != pce_pkg::STATUS_OK && corr_reg != '0, "error with nonzero result")
endmodule
`default_nettype wire

### sv/pearson_correlation_engine.sv
// Channel   Signals                                 Handshake
// input     x_sample, y_sample, last_pair           start high, busy low
// result    correlation, status                     done high for one cycle
//
// Pairs are taken one per cycle while busy is low; sums update in the cycle a beat is accepted.
// A closing pair queues its sums; the solver takes one set at a time from the
// queue, using the shared shift-add multiplier of width M (58 at defaults),
// and pops the next set only once it is idle again.
// busy rises only while the two-entry queue of finished sets is full.
// Reset clears sums, queue and solver; the receiver cannot stall results.
`default_nettype none
module pearson_correlation_engine #(
    parameter int MAX_SAMPLES   = pce_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS   = pce_pkg::DEF_SAMPLE_BITS,
    parameter int OUT_FRAC_BITS = pce_pkg::DEF_OUT_FRAC_BITS
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic signed [pce_pkg::PORT_SAMPLE_W-1:0] x_sample,
    input  wire logic signed [pce_pkg::PORT_SAMPLE_W-1:0] y_sample,
    input  wire logic                                    last_pair,
    output logic                                         done,
    output logic signed [pce_pkg::RESULT_W-1:0]          correlation,
    output logic [pce_pkg::STATUS_W-1:0]                 status
);
    localparam int CW   = $clog2(MAX_SAMPLES + 2);
    localparam int SUMW = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int PW   = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int EW   = CW + 2 * SUMW + 3 * PW;

    logic          accept, push, pop, empty, full;
    logic [EW-1:0] push_data, head;

    assign busy   = full;
    assign accept = start && !full;

    pce_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .SUMW        (SUMW),
        .PW          (PW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .x_sample  (x_sample),
        .y_sample  (y_sample),
        .last_pair (last_pair),
        .push      (push),
        .push_data (push_data)
    );

    pce_queue #(.W(EW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    pce_back #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .OUT_FRAC_BITS (OUT_FRAC_BITS),
        .CW            (CW),
        .SUMW          (SUMW),
        .PW            (PW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .done        (done),
        .correlation (correlation),
        .status      (status)
    );
endmodule
`default_nettype wire
